// ===== rtl/core/adc_calibrate_deadzone_detect_assert.svh =====
// Assertion macros shared by the calibration and dead-zone detect RTL.
`ifndef ADC_CALIBRATE_DEADZONE_DETECT_ASSERT_SVH
`define ADC_CALIBRATE_DEADZONE_DETECT_ASSERT_SVH

// Check a property on every rising clk_i edge outside reset.
`define ADCD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check that a consequent holds in the cycle after its antecedent.
`define ADCD_ASSERT_NEXT(lbl, ante, cons, msg) \
  `ADCD_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== rtl/core/adcd_pkg.sv =====
// Package with constants, register indexes and types of the calibration block.
`timescale 1ns / 1ps
package adcd_pkg;

  localparam int CHANNELS    = 4;
  localparam int SAMPLE_BITS = 12;

  // Configuration register map
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_BASE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD     = 3'd6;

  localparam int MAX_RESET    = 3000;
  localparam int CENTER_RESET = 2048;
  localparam int DEAD_RESET   = 200;

  function automatic int min_reset(input int ch);
    int val;
    case (ch)
      0, 1:    val = 8;
      2, 3:    val = 7;
      default: val = 0;
    endcase
    return val;
  endfunction

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } lane_ctrl_t;

endpackage

// ===== rtl/core/adcd_lane.sv =====
// One channel lane: range check, numerator setup and bit-serial restoring divide.
`timescale 1ns / 1ps
module adcd_lane #(
  parameter int SAMPLE_BITS = adcd_pkg::SAMPLE_BITS
) (
  input  logic                    clk_i,
  input  adcd_pkg::lane_ctrl_t    ctrl_i,
  input  logic [SAMPLE_BITS-1:0]  raw_i,
  input  logic [SAMPLE_BITS-1:0]  lo_i,
  input  logic [SAMPLE_BITS-1:0]  hi_i,
  input  logic [SAMPLE_BITS-1:0]  center_i,
  input  logic [SAMPLE_BITS-1:0]  dead_i,
  output logic [SAMPLE_BITS-1:0]  scaled_o,
  output logic                    over_o
);

  localparam int SB = SAMPLE_BITS;
  localparam logic [SB-1:0] FULL_SCALE = {SB{1'b1}};

  logic [SB-1:0]   diff;
  logic [2*SB-1:0] num;
  logic [SB-1:0]   rem_q, rem_d;
  logic [SB-1:0]   quo_q, quo_d;
  logic [SB-1:0]   div_q;
  logic            zero_q, full_q;
  logic [SB:0]     trial, trial_sub;
  logic            ge;
  logic [SB-1:0]   dev;

  // numerator = (raw - lo) * (2^SB - 1)
  assign diff = raw_i - lo_i;
  assign num  = {diff, {SB{1'b0}}} - {{SB{1'b0}}, diff};

  // One quotient bit per step; numerator low bits shift out as quotient shifts in
  assign trial     = {rem_q, quo_q[SB-1]};
  assign trial_sub = trial - {1'b0, div_q};
  assign ge        = (trial >= {1'b0, div_q});

  always_comb begin
    rem_d = ge ? trial_sub[SB-1:0] : trial[SB-1:0];
    quo_d = {quo_q[SB-2:0], ge};
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      rem_q  <= num[2*SB-1:SB];
      quo_q  <= num[SB-1:0];
      div_q  <= hi_i - lo_i;
      zero_q <= (hi_i <= lo_i) || (raw_i <= lo_i);
      full_q <= (raw_i >= hi_i);
    end else if (ctrl_i.step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // Quotient stays below full scale since raw - lo < hi - lo
  always_comb begin
    if (zero_q) begin
      scaled_o = '0;
    end else if (full_q) begin
      scaled_o = FULL_SCALE;
    end else begin
      scaled_o = quo_q;
    end
    dev    = (scaled_o >= center_i) ? (scaled_o - center_i) : (center_i - scaled_o);
    over_o = (dev > dead_i);
  end

endmodule

// ===== rtl/core/adcd_merge.sv =====
// Merge stage: combine lane flags, track idle state and hold the output register.
`timescale 1ns / 1ps
`include "adc_calibrate_deadzone_detect_assert.svh"
module adcd_merge #(
  parameter int SAMPLE_BITS = adcd_pkg::SAMPLE_BITS
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           load_i,
  input  logic [adcd_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] scaled_i,
  input  logic [adcd_pkg::CHANNELS-1:0]                  over_i,
  input  logic                                           out_stall_i,
  output logic                                           free_o,
  output logic                                           out_valid_o,
  output logic [adcd_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] scaled_o,
  output logic                                           active_o,
  output logic                                           neutral_event_o
);

  logic out_valid_q, out_valid_d;
  logic idle_seen_q, idle_seen_d;
  logic act;
  logic evt;
  logic [adcd_pkg::CHANNELS-1:0][SAMPLE_BITS-1:0] scaled_q;
  logic active_q, event_q;

  assign act    = |over_i;
  assign evt    = !act && !idle_seen_q;
  assign free_o = !out_valid_q || !out_stall_i;

  always_comb begin
    out_valid_d = out_valid_q;
    idle_seen_d = idle_seen_q;
    if (free_o) begin
      out_valid_d = 1'b0;
    end
    if (load_i) begin
      out_valid_d = 1'b1;
      idle_seen_d = !act;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idle_seen_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      idle_seen_q <= idle_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      scaled_q <= scaled_i;
      active_q <= act;
      event_q  <= evt;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign scaled_o        = scaled_q;
  assign active_o        = active_q;
  assign neutral_event_o = event_q;

  `ADCD_ASSERT(a_evt_not_active, !(out_valid_q && event_q && active_q), "event with activity")
  `ADCD_ASSERT_NEXT(a_load_when_free, load_i && !free_o, 1'b0, "load into a busy output")

endmodule

// ===== rtl/core/adc_calibrate_deadzone_detect.sv =====
// Top level: joystick ADC min/max calibration with dead-zone activity detection.
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+----------------------------------------
//  in      | request   | in_valid_i / in_stall_o  | sample_ch0_i..sample_ch3_i
//  out     | result    | out_valid_o / out_stall_i| scaled_ch0_o..scaled_ch3_o, active_o,
//          |           |                          | neutral_event_o
//  cfg     | write     | cfg_we_i                 | cfg_idx_i, cfg_data_i
//
//  A request passes through a load step, one divide step per quotient bit in the
//  restoring divider of every lane, and a merge step that waits for a free output.
//  The lanes run in lockstep; a new request waits until the last one has merged.
//  Reset is asynchronous and active low; it clears the controller, the output valid
//  and the idle flag, and restores the calibration registers. No clearing pass.
//  A stalled result waits in the output register; the next request is accepted and
//  divided meanwhile, and its merge holds until the output register frees up.
`timescale 1ns / 1ps
`include "adc_calibrate_deadzone_detect_assert.svh"
module adc_calibrate_deadzone_detect #(
  parameter int SAMPLE_BITS = adcd_pkg::SAMPLE_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [adcd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SAMPLE_BITS-1:0]         cfg_data_i,
  // request channel
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [SAMPLE_BITS-1:0]         sample_ch0_i,
  input  logic [SAMPLE_BITS-1:0]         sample_ch1_i,
  input  logic [SAMPLE_BITS-1:0]         sample_ch2_i,
  input  logic [SAMPLE_BITS-1:0]         sample_ch3_i,
  // result channel
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [SAMPLE_BITS-1:0]         scaled_ch0_o,
  output logic [SAMPLE_BITS-1:0]         scaled_ch1_o,
  output logic [SAMPLE_BITS-1:0]         scaled_ch2_o,
  output logic [SAMPLE_BITS-1:0]         scaled_ch3_o,
  output logic                           active_o,
  output logic                           neutral_event_o
);

  localparam int CH    = adcd_pkg::CHANNELS;
  localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLE_BITS - 1);

  // ---------------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------------
  logic [CH-1:0][SAMPLE_BITS-1:0] min_q;
  logic [SAMPLE_BITS-1:0]         max_q;
  logic [SAMPLE_BITS-1:0]         center_q;
  logic [SAMPLE_BITS-1:0]         dead_q;

  for (genvar ch = 0; ch < CH; ch++) begin : g_min
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        min_q[ch] <= SAMPLE_BITS'(adcd_pkg::min_reset(ch));
      end else if (cfg_we_i &&
                   cfg_idx_i == adcd_pkg::REG_MIN_BASE + adcd_pkg::CFG_IDX_W'(ch)) begin
        min_q[ch] <= cfg_data_i;
      end
    end
  end

  // Unknown indexes fall through and leave every register alone
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q    <= SAMPLE_BITS'(adcd_pkg::MAX_RESET);
      center_q <= SAMPLE_BITS'(adcd_pkg::CENTER_RESET);
      dead_q   <= SAMPLE_BITS'(adcd_pkg::DEAD_RESET);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        adcd_pkg::REG_MAX:    max_q    <= cfg_data_i;
        adcd_pkg::REG_CENTER: center_q <= cfg_data_i;
        adcd_pkg::REG_DEAD:   dead_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Controller: load lanes, step the dividers, hand off to the merge stage
  // ---------------------------------------------------------------------------
  adcd_pkg::ctrl_state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  adcd_pkg::lane_ctrl_t  lane_ctrl;
  logic                  in_accept;
  logic                  in_done;
  logic                  merge_free;
  logic                  merge_load;

  assign in_stall_o = (state_q != adcd_pkg::ST_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_done    = (state_q == adcd_pkg::ST_DONE);

  always_comb begin
    state_d        = state_q;
    cnt_d          = cnt_q;
    lane_ctrl.load = 1'b0;
    lane_ctrl.step = 1'b0;
    merge_load     = 1'b0;
    case (state_q)
      adcd_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          lane_ctrl.load = 1'b1;
          cnt_d          = '0;
          state_d        = adcd_pkg::ST_DIV;
        end
      end
      adcd_pkg::ST_DIV: begin
        lane_ctrl.step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = adcd_pkg::ST_DONE;
        end
      end
      adcd_pkg::ST_DONE: begin
        // hold the quotients until the output register can take them
        if (merge_free) begin
          merge_load = 1'b1;
          state_d    = adcd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = adcd_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= adcd_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Lanes, one per channel
  // ---------------------------------------------------------------------------
  logic [CH-1:0][SAMPLE_BITS-1:0] raw;
  logic [CH-1:0][SAMPLE_BITS-1:0] lane_scaled;
  logic [CH-1:0]                  lane_over;
  logic [CH-1:0][SAMPLE_BITS-1:0] out_scaled;

  assign raw[0] = sample_ch0_i;
  assign raw[1] = sample_ch1_i;
  assign raw[2] = sample_ch2_i;
  assign raw[3] = sample_ch3_i;

  for (genvar ch = 0; ch < CH; ch++) begin : g_lane
    adcd_lane #(
      .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane (
      .clk_i   (clk_i),
      .ctrl_i  (lane_ctrl),
      .raw_i   (raw[ch]),
      .lo_i    (min_q[ch]),
      .hi_i    (max_q),
      .center_i(center_q),
      .dead_i  (dead_q),
      .scaled_o(lane_scaled[ch]),
      .over_o  (lane_over[ch])
    );
  end

  // ---------------------------------------------------------------------------
  // Merge and output register
  // ---------------------------------------------------------------------------
  adcd_merge #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_merge (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .load_i         (merge_load),
    .scaled_i       (lane_scaled),
    .over_i         (lane_over),
    .out_stall_i    (out_stall_i),
    .free_o         (merge_free),
    .out_valid_o    (out_valid_o),
    .scaled_o       (out_scaled),
    .active_o       (active_o),
    .neutral_event_o(neutral_event_o)
  );

  assign scaled_ch0_o = out_scaled[0];
  assign scaled_ch1_o = out_scaled[1];
  assign scaled_ch2_o = out_scaled[2];
  assign scaled_ch3_o = out_scaled[3];

  `ADCD_ASSERT_NEXT(a_accept_starts_div, in_accept, state_q == adcd_pkg::ST_DIV, "accept lost")
  `ADCD_ASSERT(a_cnt_in_range, (state_q != adcd_pkg::ST_DIV) || (cnt_q <= CNT_LAST), "step overrun")
  `ADCD_ASSERT(a_result_from_done, $rose(out_valid_o) |-> $past(in_done), "result without divide")

endmodule

// ===== verif/adc_calibrate_deadzone_detect_tb.sv =====
// Testbench for the joystick ADC calibration and dead-zone detect block.
`timescale 1ns / 1ps
module adc_calibrate_deadzone_detect_tb;

  localparam int CHANNELS    = adcd_pkg::CHANNELS;
  localparam int SAMPLE_BITS = adcd_pkg::SAMPLE_BITS;
  localparam int CFG_IDX_W   = adcd_pkg::CFG_IDX_W;
  localparam int CH_IDX_W    = $clog2(CHANNELS);

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] chan_set_t;

  // One calibrated reading as the block reports it.
  typedef struct packed {
    chan_set_t scaled;
    logic      active;
    logic      neutral_event;
  } reading_t;

  localparam sample_t FULL_SCALE = '1;
  // Index 7 has no register behind it; writes there must be dropped.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 40;
  localparam int BATCHES        = 8;
  localparam int BATCH_ITEMS    = 59;

  logic                 clk_i        = 1'b0;
  logic                 rst_ni       = 1'b0;
  logic                 cfg_we_i     = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i    = '0;
  sample_t              cfg_data_i   = '0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  sample_t              sample_ch0_i = '0;
  sample_t              sample_ch1_i = '0;
  sample_t              sample_ch2_i = '0;
  sample_t              sample_ch3_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  sample_t              scaled_ch0_o;
  sample_t              scaled_ch1_o;
  sample_t              scaled_ch2_o;
  sample_t              scaled_ch3_o;
  logic                 active_o;
  logic                 neutral_event_o;

  // Mirror of the calibration registers and the idle flag, at reset values.
  sample_t cal_min [CHANNELS] = '{12'd8, 12'd8, 12'd7, 12'd7};
  sample_t cal_max     = sample_t'(adcd_pkg::MAX_RESET);
  sample_t cal_center  = sample_t'(adcd_pkg::CENTER_RESET);
  sample_t cal_dead    = sample_t'(adcd_pkg::DEAD_RESET);
  logic    idle_seen   = 1'b0;

  reading_t expected_readings [$];
  int       mismatch_count = 0;
  int       quiet_cycles   = 0;
  int       send_idle_pct  = 0;
  int       recv_stall_pct = 0;

  adc_calibrate_deadzone_detect dut (.*);

  always #5 clk_i = ~clk_i;

  // Receiver backpressure: redraw the stall once per cycle on the falling edge.
  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Map a raw sample from [lo, hi] onto 0..FULL_SCALE, truncating the quotient.
  function automatic sample_t scale_reading(sample_t raw, sample_t lo, sample_t hi);
    int unsigned quo;
    if (hi <= lo) return '0;
    if (raw <= lo) return '0;
    if (raw >= hi) return FULL_SCALE;
    quo = ((32'(raw) - 32'(lo)) * 32'(FULL_SCALE)) / (32'(hi) - 32'(lo));
    if (quo > 32'(FULL_SCALE)) quo = 32'(FULL_SCALE);
    return sample_t'(quo);
  endfunction

  // Scale all channels, flag deflection past the dead band, and advance the
  // idle flag so that only the first idle request after activity raises the event.
  function automatic reading_t calibrate_and_classify(chan_set_t raw);
    reading_t    r;
    int unsigned dev;
    r.active        = 1'b0;
    r.neutral_event = 1'b0;
    for (int ch = 0; ch < CHANNELS; ch++) begin
      r.scaled[ch] = scale_reading(raw[ch], cal_min[ch], cal_max);
      dev = (r.scaled[ch] >= cal_center) ? 32'(r.scaled[ch]) - 32'(cal_center)
                                         : 32'(cal_center) - 32'(r.scaled[ch]);
      if (dev > 32'(cal_dead)) r.active = 1'b1;
    end
    if (r.active) begin
      idle_seen = 1'b0;
    end else if (!idle_seen) begin
      r.neutral_event = 1'b1;
      idle_seen       = 1'b1;
    end
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  // Compare every accepted result with the oldest pending expectation.
  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.scaled        = {scaled_ch3_o, scaled_ch2_o, scaled_ch1_o, scaled_ch0_o};
      got.active        = active_o;
      got.neutral_event = neutral_event_o;
      if (expected_readings.size() == 0) begin
        $error("result with no request pending: scaled %h active %b event %b",
               got.scaled, got.active, got.neutral_event);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        for (int ch = 0; ch < CHANNELS; ch++) begin
          if (got.scaled[ch] !== want.scaled[ch]) begin
            $error("scaled_ch%0d: expected %0d, actual %0d",
                   ch, want.scaled[ch], got.scaled[ch]);
            mismatch_count++;
          end
        end
        if (got.active !== want.active) begin
          $error("active: expected %0d, actual %0d", want.active, got.active);
          mismatch_count++;
        end
        if (got.neutral_event !== want.neutral_event) begin
          $error("neutral_event: expected %0d, actual %0d",
                 want.neutral_event, got.neutral_event);
          mismatch_count++;
        end
      end
    end
  end

  // Abort when neither channel moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $error("watchdog: no handshake for %0d cycles, %0d results pending",
               WATCHDOG_LIMIT, expected_readings.size());
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  function automatic chan_set_t pack_samples(int c0, int c1, int c2, int c3);
    chan_set_t s;
    s[0] = sample_t'(c0);
    s[1] = sample_t'(c1);
    s[2] = sample_t'(c2);
    s[3] = sample_t'(c3);
    return s;
  endfunction

  // Write one register and update the mirror; hold the enable for one edge.
  task automatic program_register(logic [CFG_IDX_W-1:0] idx, sample_t value);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    if (idx < adcd_pkg::REG_MAX) cal_min[CH_IDX_W'(idx - adcd_pkg::REG_MIN_BASE)] = value;
    else if (idx == adcd_pkg::REG_MAX) cal_max = value;
    else if (idx == adcd_pkg::REG_CENTER) cal_center = value;
    else if (idx == adcd_pkg::REG_DEAD) cal_dead = value;
  endtask

  task automatic program_calibration(chan_set_t mins, sample_t hi, sample_t mid,
                                     sample_t band);
    for (int ch = 0; ch < CHANNELS; ch++) begin
      program_register(CFG_IDX_W'(adcd_pkg::REG_MIN_BASE + ch), mins[ch]);
    end
    program_register(adcd_pkg::REG_MAX, hi);
    program_register(adcd_pkg::REG_CENTER, mid);
    program_register(adcd_pkg::REG_DEAD, band);
  endtask

  // Send one request, idling first at the configured rate, and record the
  // expected result once the block takes it.
  task automatic send_samples(chan_set_t s);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    sample_ch0_i <= s[0];
    sample_ch1_i <= s[1];
    sample_ch2_i <= s[2];
    sample_ch3_i <= s[3];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    expected_readings.push_back(calibrate_and_classify(s));
  endtask

  // Drop valid and hold until every pending result has come back.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Random stimulus
  // ---------------------------------------------------------------------------

  // Draw a calibration: mostly realistic ranges, some empty and extreme ones.
  task automatic randomize_calibration();
    chan_set_t mins;
    sample_t   hi;
    sample_t   mid;
    sample_t   band;
    int        pick;
    pick = $urandom_range(9);
    case (pick)
      0: begin
        mins = '0;
        hi   = FULL_SCALE;
        mid  = sample_t'($urandom_range(4095));
        band = sample_t'($urandom_range(400));
      end
      1: begin
        // Empty ranges on some channels: minimum at or above the maximum.
        hi = sample_t'($urandom_range(4095));
        for (int ch = 0; ch < CHANNELS; ch++) begin
          mins[ch] = sample_t'($urandom_range(4095, (hi > 100) ? hi - 100 : 0));
        end
        mid  = sample_t'(adcd_pkg::CENTER_RESET);
        band = sample_t'($urandom_range(300));
      end
      2: begin
        for (int ch = 0; ch < CHANNELS; ch++) mins[ch] = sample_t'($urandom_range(4095));
        hi   = sample_t'($urandom_range(4095));
        mid  = sample_t'($urandom_range(4095));
        band = sample_t'($urandom_range(4095));
      end
      3: begin
        for (int ch = 0; ch < CHANNELS; ch++) mins[ch] = sample_t'($urandom_range(50));
        hi   = FULL_SCALE;
        mid  = $urandom_range(1) ? FULL_SCALE : '0;
        band = $urandom_range(1) ? FULL_SCALE : '0;
      end
      default: begin
        for (int ch = 0; ch < CHANNELS; ch++) mins[ch] = sample_t'($urandom_range(300));
        hi   = sample_t'($urandom_range(4095, 2500));
        mid  = $urandom_range(1) ? sample_t'(adcd_pkg::CENTER_RESET)
                                 : sample_t'($urandom_range(2300, 1800));
        band = sample_t'($urandom_range(600));
      end
    endcase
    program_calibration(mins, hi, mid, band);
  endtask

  // Mostly sticks at rest jittering around the dead-band edge, then free
  // deflection, then the range edges.
  function automatic chan_set_t make_sample_set();
    chan_set_t s;
    int        kind;
    int        span;
    int        rest;
    int        reach;
    int        v;
    kind = int'($urandom_range(9));
    for (int ch = 0; ch < CHANNELS; ch++) begin
      span = int'(cal_max) - int'(cal_min[ch]);
      if (span > 0) begin
        rest  = int'(cal_min[ch]) + int'(cal_center) * span / 4095;
        reach = (int'(cal_dead) + 8) * span / 4095 + 2;
      end else begin
        rest  = int'($urandom_range(4095));
        reach = 50;
      end
      if (kind <= 5 || (kind <= 7 && $urandom_range(1))) begin
        v = rest + int'($urandom_range(2 * reach)) - reach;
      end else if (kind <= 7) begin
        v = int'($urandom_range(4095));
      end else begin
        case ($urandom_range(5))
          0:       v = 0;
          1:       v = 4095;
          2:       v = int'(cal_min[ch]);
          3:       v = int'(cal_min[ch]) + 1;
          4:       v = int'(cal_max);
          default: v = int'(cal_max) - 1;
        endcase
      end
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      s[ch] = sample_t'(v);
    end
    return s;
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset calibration: range edges and the idle-event sequence.
  task automatic test_scaling_extremes();
    send_samples(pack_samples(0, 0, 0, 0));
    send_samples(pack_samples(4095, 4095, 4095, 4095));
    send_samples(pack_samples(8, 8, 7, 7));
    send_samples(pack_samples(9, 9, 8, 8));
    send_samples(pack_samples(3000, 3000, 3000, 3000));
    send_samples(pack_samples(2999, 2999, 2999, 2999));
    // Rest position: the first idle request raises the event, the second not.
    send_samples(pack_samples(1504, 1504, 1503, 1503));
    send_samples(pack_samples(1504, 1504, 1503, 1503));
    send_samples(pack_samples(1504, 4095, 1503, 1503));
    send_samples(pack_samples(1504, 1504, 1503, 1503));
  endtask

  // Identity scaling so that deflection equals the raw offset from center.
  task automatic test_dead_band_edges();
    drain_results();
    program_calibration('0, FULL_SCALE, 12'd2048, 12'd200);
    send_samples(pack_samples(2248, 2048, 2048, 2048));
    send_samples(pack_samples(2048, 1848, 2048, 2048));
    send_samples(pack_samples(2048, 2048, 2249, 2048));
    send_samples(pack_samples(2048, 2048, 2048, 1847));
    drain_results();
    program_register(adcd_pkg::REG_DEAD, '0);
    send_samples(pack_samples(2048, 2048, 2048, 2048));
    send_samples(pack_samples(2048, 2049, 2048, 2048));
    drain_results();
    program_register(adcd_pkg::REG_CENTER, '0);
    send_samples(pack_samples(0, 0, 0, 0));
    drain_results();
    program_register(adcd_pkg::REG_CENTER, FULL_SCALE);
    program_register(adcd_pkg::REG_DEAD, FULL_SCALE);
    send_samples(pack_samples(0, 4095, 0, 0));
  endtask

  // Maximum at or below the minimum, and a write to the unmapped index.
  task automatic test_empty_range();
    drain_results();
    program_calibration(pack_samples(100, 100, 100, 100), 12'd100, 12'd2048, 12'd200);
    send_samples(pack_samples(4095, 100, 0, 2000));
    drain_results();
    program_calibration(pack_samples(4095, 4095, 4095, 4095), '0, 12'd0, 12'd0);
    send_samples(pack_samples(4095, 0, 4095, 0));
    drain_results();
    program_calibration('0, '0, 12'd2048, 12'd200);
    send_samples(pack_samples(4095, 0, 1, 2048));
    drain_results();
    program_register(REG_UNMAPPED, 12'd5);
    send_samples(pack_samples(4095, 0, 1, 2048));
  endtask

  // Batches of random requests, recalibrating between batches; pause once
  // mid-phase until the block has returned everything.
  task automatic test_random_traffic(int idle_pct, int stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int b = 0; b < BATCHES; b++) begin
      drain_results();
      randomize_calibration();
      for (int n = 0; n < BATCH_ITEMS; n++) begin
        if (b == BATCHES / 2 && n == BATCH_ITEMS / 2) drain_results();
        send_samples(make_sample_set());
      end
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    send_idle_pct  = 20;
    recv_stall_pct = 54;
    test_scaling_extremes();
    test_dead_band_edges();
    test_empty_range();
    test_random_traffic(20, 54);
    test_random_traffic(54, 20);
    test_random_traffic(0, 0);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (expected_readings.size() != 0) begin
      $error("%0d expected results never arrived", expected_readings.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
